// ===== rtl/doc_vector_record_parser_unit_macros.svh =====
// assertion macros for the document-vector record parser
// expect clk and arst_n in scope at the point of use
`ifndef DOC_VECTOR_RECORD_PARSER_UNIT_MACROS_SVH
`define DOC_VECTOR_RECORD_PARSER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define DVRP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dvrp assertion failed");

// next-cycle implication, checked outside reset
`define DVRP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dvrp assertion failed");

`endif

// ===== rtl/dvrp_pkg.sv =====
// types and codes shared by the document-vector record parser
// no dependencies
`timescale 1ns / 1ps

package dvrp_pkg;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_ENTRY  = 2'd1,
		PH_ENDED  = 2'd2,
		PH_HALTED = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		KIND_DOC      = 3'd0,
		KIND_ENTRY    = 3'd1,
		KIND_END      = 3'd2,
		KIND_HDR_ERR  = 3'd3,
		KIND_BODY_ERR = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		REG_HEADER_FLAG = 2'd0,
		REG_BODY_FLAG   = 2'd1,
		REG_END_FLAG    = 2'd2
	} reg_index_t;

	localparam logic [7:0] HEADER_FLAG_RESET = 8'd1;
	localparam logic [7:0] BODY_FLAG_RESET   = 8'd2;
	localparam logic [7:0] END_FLAG_RESET    = 8'd0;

	// last byte index of a header and of an entry
	localparam logic [3:0] HDR_LAST_POS   = 4'd7;
	localparam logic [3:0] ENTRY_LAST_POS = 4'd15;

	typedef struct packed {
		logic [7:0] header_flag;
		logic [7:0] body_flag;
		logic [7:0] end_flag;
	} cfg_t;

	typedef struct packed {
		kind_t        result_kind;
		logic [23:0]  doc_number;
		logic [30:0]  entry_total;
		logic [23:0]  term_number;
		logic [63:0]  weight_bits;
	} result_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  pos;
	} status_t;

endpackage

// ===== rtl/doc_vector_record_parser_unit.sv =====
// top level of the document-vector record parser
// depends on dvrp_pkg, dvrp_core, dvrp_outq and the assertion macro header
`timescale 1ns / 1ps

// Parses a stored document-vector file one byte per request and takes a new byte
// every cycle while in_ready is high; the parse state advances in the cycle a
// byte is accepted and its result, if any, goes to the output queue. Each
// document is an 8-byte header (flag, 24-bit id, 32-bit count) followed by that
// many 16-byte entries; a header result comes after the last header byte and an
// entry result after the last entry byte, carrying the raw 64-bit value. A result
// register with a one-entry skid stage behind it keeps in_ready up while one
// result waits, so in_ready drops only when two results are held. A wrong flag
// halts parsing and an end flag stops it until a byte with stream_start. Flag
// registers are written through the cfg port while the block is idle, which the
// user must ensure, not the block; index 0 header flag, 1 body flag, 2 end flag, 3 ignored.
module doc_vector_record_parser_unit import dvrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        stream_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  result_kind,
	output logic [23:0] doc_number,
	output logic [30:0] entry_total,
	output logic [23:0] term_number,
	output logic [63:0] weight_bits,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	`include "doc_vector_record_parser_unit_macros.svh"

	cfg_t    cfg_q;
	logic    accept;
	logic    res_valid;
	result_t res;
	result_t head;
	status_t status;
	logic    space;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_flag <= HEADER_FLAG_RESET;
			cfg_q.body_flag   <= BODY_FLAG_RESET;
			cfg_q.end_flag    <= END_FLAG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_HEADER_FLAG: cfg_q.header_flag <= cfg_data;
				REG_BODY_FLAG:   cfg_q.body_flag   <= cfg_data;
				REG_END_FLAG:    cfg_q.end_flag    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_ready = space;
	assign accept   = in_valid && in_ready;

	dvrp_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.accept       (accept),
		.data_byte    (data_byte),
		.stream_start (stream_start),
		.res_valid    (res_valid),
		.res          (res),
		.status       (status)
	);

	dvrp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign result_kind = head.result_kind;
	assign doc_number  = head.doc_number;
	assign entry_total = head.entry_total;
	assign term_number = head.term_number;
	assign weight_bits = head.weight_bits;

	// back-pressure only once a result is already waiting
	`DVRP_ASSERT_IMPL(a_stall_needs_result, !in_ready, out_valid)
	// a halted parser stays halted until a stream start arrives
	`DVRP_ASSERT_NEXT(a_halt_sticks,
		status.phase == PH_HALTED && !(accept && stream_start),
		status.phase == PH_HALTED)
	// header byte index never runs past the last header byte
	`DVRP_ASSERT_IMPL(a_hdr_pos_range, status.phase == PH_HEADER,
		status.pos <= HDR_LAST_POS)
	// a request that cannot produce a result leaves the output side alone
	`DVRP_ASSERT_NEXT(a_ended_silent,
		status.phase == PH_ENDED && accept && !stream_start && !out_valid,
		!out_valid)

endmodule

// ===== rtl/dvrp_core.sv =====
// byte-level parse state and result formation for one accepted request
// depends on dvrp_pkg
`timescale 1ns / 1ps

module dvrp_core import dvrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	input  logic        stream_start,
	output logic        res_valid,
	output result_t     res,
	output status_t     status
);

	phase_t      phase_q, phase_d;
	logic [3:0]  pos_q, pos_d;
	logic [23:0] doc_q, doc_d;
	logic [30:0] left_q, left_d;
	logic [30:0] total_q, total_d;
	logic [23:0] term_q, term_d;
	logic [63:0] shift_q, shift_d;

	phase_t      phase_eff;
	logic [3:0]  pos_eff;
	logic [31:0] hdr_shift;
	logic [30:0] total_new;
	logic [63:0] val_shift;
	logic [30:0] left_dec;

	// a stream start restarts at header byte zero with this byte
	assign phase_eff = stream_start ? PH_HEADER : phase_q;
	assign pos_eff   = stream_start ? 4'd0 : pos_q;

	assign hdr_shift = {shift_q[23:0], data_byte};
	// a count with the top bit set means no entries
	assign total_new = hdr_shift[31] ? 31'd0 : hdr_shift[30:0];
	assign val_shift = {shift_q[55:0], data_byte};
	assign left_dec  = (left_q != 31'd0) ? (left_q - 31'd1) : left_q;

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		doc_d   = doc_q;
		left_d  = left_q;
		total_d = total_q;
		term_d  = term_q;
		shift_d = shift_q;
		if (accept) begin
			phase_d = phase_eff;
			pos_d   = pos_eff;
			unique case (phase_eff)
				PH_HEADER: begin
					if (pos_eff == 4'd0) begin
						if (data_byte == cfg.end_flag) begin
							phase_d = PH_ENDED;
						end else if (data_byte != cfg.header_flag) begin
							phase_d = PH_HALTED;
						end else begin
							pos_d = 4'd1;
						end
					end else if (pos_eff <= 4'd3) begin
						doc_d = {doc_q[15:0], data_byte};
						pos_d = pos_eff + 4'd1;
					end else if (pos_eff < HDR_LAST_POS) begin
						shift_d = {32'd0, hdr_shift};
						pos_d   = pos_eff + 4'd1;
					end else begin
						total_d = total_new;
						left_d  = total_new;
						shift_d = '0;
						pos_d   = 4'd0;
						phase_d = (total_new == 31'd0) ? PH_HEADER : PH_ENTRY;
					end
				end
				PH_ENTRY: begin
					if (pos_eff == 4'd0) begin
						if (data_byte != cfg.body_flag) begin
							phase_d = PH_HALTED;
						end else begin
							shift_d = '0;
							pos_d   = 4'd1;
						end
					end else begin
						if (pos_eff <= 4'd3) begin
							term_d = {term_q[15:0], data_byte};
						end else if (pos_eff <= 4'd7 || pos_eff >= 4'd12) begin
							// duplicate flag and id bytes fall in between and are skipped
							shift_d = val_shift;
						end
						if (pos_eff < ENTRY_LAST_POS) begin
							pos_d = pos_eff + 4'd1;
						end else begin
							pos_d  = 4'd0;
							left_d = left_dec;
							if (left_dec == 31'd0) begin
								phase_d = PH_HEADER;
							end
						end
					end
				end
				PH_ENDED, PH_HALTED: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (accept) begin
			unique case (phase_eff)
				PH_HEADER: begin
					if (pos_eff == 4'd0) begin
						if (data_byte == cfg.end_flag) begin
							res_valid       = 1'b1;
							res.result_kind = KIND_END;
						end else if (data_byte != cfg.header_flag) begin
							res_valid       = 1'b1;
							res.result_kind = KIND_HDR_ERR;
						end
					end else if (pos_eff == HDR_LAST_POS) begin
						res_valid       = 1'b1;
						res.result_kind = KIND_DOC;
						res.doc_number  = doc_q;
						res.entry_total = total_new;
					end
				end
				PH_ENTRY: begin
					if (pos_eff == 4'd0) begin
						if (data_byte != cfg.body_flag) begin
							res_valid       = 1'b1;
							res.result_kind = KIND_BODY_ERR;
						end
					end else if (pos_eff == ENTRY_LAST_POS) begin
						res_valid       = 1'b1;
						res.result_kind = KIND_ENTRY;
						res.doc_number  = doc_q;
						res.entry_total = total_q;
						res.term_number = term_q;
						res.weight_bits = val_shift;
					end
				end
				PH_ENDED, PH_HALTED: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			doc_q   <= '0;
			left_q  <= '0;
			total_q <= '0;
			term_q  <= '0;
			shift_q <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			doc_q   <= doc_d;
			left_q  <= left_d;
			total_q <= total_d;
			term_q  <= term_d;
			shift_q <= shift_d;
		end
	end

	assign status.phase = phase_q;
	assign status.pos   = pos_q;

endmodule

// ===== rtl/dvrp_outq.sv =====
// result register with a skid stage behind it
// depends on dvrp_pkg
`timescale 1ns / 1ps

module dvrp_outq import dvrp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    space,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t head
);

	logic    head_valid_q;
	logic    skid_valid_q;
	result_t head_q;
	result_t skid_q;
	logic    head_free;

	assign head_free = !head_valid_q || out_ready;
	// the skid entry is empty whenever a new request can land
	assign space     = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (head_free) begin
			if (skid_valid_q) begin
				head_valid_q <= 1'b1;
				skid_valid_q <= push;
			end else begin
				head_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (head_free) begin
			if (skid_valid_q) begin
				head_q <= skid_q;
				skid_q <= push_data;
			end else begin
				head_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign out_valid = head_valid_q;
	assign head      = head_q;

endmodule
